FILE: sv/wfba_pkg.sv
//------------------------------------------------------------------------------
// wfba_pkg
// Shared constants, codes and controller/datapath types for the worst-fit
// block allocator.
//------------------------------------------------------------------------------
`default_nettype none

package wfba_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int SIZE_W       = 32;
    localparam int SEG_W        = SIZE_W + 1;   // {used, size}
    localparam int NEED_W       = 17;           // request (16b) + header (7b)
    localparam int CFG_IDX_W    = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT   = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_REUSED   = 3'd0,
        ST_APPENDED = 3'd1,
        ST_FREED    = 3'd2,
        ST_NO_ROOM  = 3'd3,
        ST_UNKNOWN  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC_FIN,
        S_FREE_NX,
        S_FREE_SUM,
        S_FREE_MG,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic scan;
        logic alloc_fin;
        logic free_nx;
        logic free_sum;
        logic free_mg;
        logic sh_rd;
        logic sh_wr;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic match;
        logic is_free;
        logic out_free;
        logic merge_last;
        logic need_shift;
        logic shift_last;
    } t_sts;

endpackage

`default_nettype wire

FILE: sv/wfba_chan_if.sv
//------------------------------------------------------------------------------
// wfba channel interfaces
// Request and result channels, valid/ready handshake.
//------------------------------------------------------------------------------
`default_nettype none

interface wfba_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] request_size;
    logic [31:0] block_address;

    modport source (output valid, op, request_size, block_address, input ready);
    modport sink   (input valid, op, request_size, block_address, output ready);
endinterface

interface wfba_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_address;
    logic [2:0]  status;
    logic [31:0] heap_used;

    modport source (output valid, result_address, status, heap_used, input ready);
    modport sink   (input valid, result_address, status, heap_used, output ready);
endinterface

`default_nettype wire

FILE: sv/wfba_ram.sv
//------------------------------------------------------------------------------
// wfba_ram
// Simple dual-port RAM: one write port, one read port, registered read.
//------------------------------------------------------------------------------
`default_nettype none

module wfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: sv/wfba_ctrl.sv
//------------------------------------------------------------------------------
// wfba_ctrl
// Sequencer: table scan, allocate finish, free merge and table compaction.
//------------------------------------------------------------------------------
`default_nettype none

module wfba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wfba_pkg::t_sts i_sts,
    output wfba_pkg::t_cmd o_cmd
);
    import wfba_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_sts.count_zero ? S_ALLOC_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.match) begin
                    n_state = S_FREE_NX;
                end else if (i_sts.scan_last) begin
                    n_state = i_sts.is_free ? S_DONE : S_ALLOC_FIN;
                end
            end
            S_ALLOC_FIN: begin
                // empty table on a free lands here too: result stays unknown
                o_cmd.alloc_fin = !i_sts.is_free;
                n_state         = S_DONE;
            end
            S_FREE_NX: begin
                o_cmd.free_nx = 1'b1;
                n_state       = S_FREE_SUM;
            end
            S_FREE_SUM: begin
                o_cmd.free_sum = 1'b1;
                n_state        = S_FREE_MG;
            end
            S_FREE_MG: begin
                o_cmd.free_mg = 1'b1;
                if (!i_sts.merge_last && i_sts.need_shift) begin
                    n_state = S_SH_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SH_RD: begin
                o_cmd.sh_rd = 1'b1;
                n_state     = S_SH_WR;
            end
            S_SH_WR: begin
                o_cmd.sh_wr = 1'b1;
                n_state     = i_sts.shift_last ? S_DONE : S_SH_RD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/wfba_dpath.sv
//------------------------------------------------------------------------------
// wfba_dpath
// Segment table RAM, config registers, scan/merge arithmetic, result register.
//------------------------------------------------------------------------------
`default_nettype none

module wfba_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  wfba_pkg::t_cmd                     i_cmd,
    output wfba_pkg::t_sts                     o_sts,
    input  logic                               i_cfg_we,
    input  logic [wfba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    input  logic                               i_op,
    input  logic [15:0]                        i_request_size,
    input  logic [31:0]                        i_block_address,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [31:0]                        o_result_address,
    output logic [2:0]                         o_status,
    output logic [31:0]                        o_heap_used
);
    import wfba_pkg::*;

    // config and architectural state
    logic [31:0]       r_heap_base;
    logic [6:0]        r_header;
    logic [31:0]       r_heap_limit;
    logic [CNT_W-1:0]  r_count;
    logic [31:0]       r_top;
    logic              r_out_valid;

    // per-item working registers
    logic              r_op_free;
    logic [NEED_W-1:0] r_need;
    logic [31:0]       r_baddr;
    logic [31:0]       r_basehdr;
    logic [IDX_W-1:0]  r_idx;
    logic [31:0]       r_off;
    logic [31:0]       r_best;
    logic [IDX_W-1:0]  r_pick;
    logic [31:0]       r_pick_off;
    logic              r_found;
    logic [31:0]       r_prev_size;
    logic              r_prev_used;
    logic [IDX_W-1:0]  r_i;
    logic [31:0]       r_s;
    logic [IDX_W-1:0]  r_m;
    logic [1:0]        r_k;
    logic [CNT_W-1:0]  r_cntp;
    logic              r_pf;
    logic [CNT_W-1:0]  r_j;
    logic [31:0]       r_res_addr;
    t_status           r_res_status;
    logic [31:0]       r_out_addr;
    logic [2:0]        r_out_status;
    logic [31:0]       r_out_used;

    // table access
    logic [SEG_W-1:0]  w_rdata;
    logic [SEG_W-1:0]  w_wdata;
    logic [IDX_W-1:0]  w_raddr;
    logic [IDX_W-1:0]  w_waddr;
    logic              w_we;
    logic [31:0]       rd_size;
    logic              rd_used;

    logic [32:0]       w_app_sum;
    logic              w_no_room;
    logic              w_match;
    logic              w_nx_exists;
    logic              w_next_free;
    logic              w_prev_free;
    logic [1:0]        w_k;
    logic              w_merge_last;
    logic [CNT_W-1:0]  w_shift_src;

    assign rd_size = w_rdata[SIZE_W-1:0];
    assign rd_used = w_rdata[SIZE_W];

    assign w_app_sum = {1'b0, r_top} + {{(33-NEED_W){1'b0}}, r_need};
    assign w_no_room = (r_count == CNT_W'(MAX_SEGMENTS)) || (w_app_sum > {1'b0, r_heap_limit});
    assign w_match   = r_op_free && ((r_basehdr + r_off) == r_baddr);

    assign w_nx_exists  = (({1'b0, r_i} + CNT_W'(1)) < r_count);
    assign w_next_free  = w_nx_exists && !rd_used;
    assign w_prev_free  = (r_i != '0) && !r_prev_used;
    assign w_k          = {1'b0, w_prev_free} + {1'b0, w_next_free};
    assign w_merge_last = (({1'b0, r_m} + CNT_W'(1)) == r_cntp);
    assign w_shift_src  = r_j + CNT_W'(r_k);

    always_comb begin
        o_sts            = '0;
        o_sts.count_zero = (r_count == '0);
        o_sts.scan_last  = (({1'b0, r_idx} + CNT_W'(1)) == r_count);
        o_sts.match      = w_match;
        o_sts.is_free    = r_op_free;
        o_sts.out_free   = !r_out_valid || i_out_ready;
        o_sts.merge_last = w_merge_last;
        o_sts.need_shift = (r_k != '0);
        o_sts.shift_last = ((r_j + CNT_W'(1)) == r_cntp);
    end

    // read port: entry 0 on start, next entry while scanning, source on shift
    always_comb begin
        if (i_cmd.scan) begin
            w_raddr = r_idx + IDX_W'(1);
        end else if (i_cmd.sh_rd) begin
            w_raddr = w_shift_src[IDX_W-1:0];
        end else begin
            w_raddr = '0;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        if (i_cmd.alloc_fin) begin
            w_we    = r_found || !w_no_room;
            w_waddr = r_found ? r_pick : r_count[IDX_W-1:0];
            w_wdata = r_found ? {1'b1, r_best}
                              : {1'b1, {(SIZE_W-NEED_W){1'b0}}, r_need};
        end else if (i_cmd.free_mg) begin
            w_we    = !w_merge_last;
            w_waddr = r_m;
            w_wdata = {1'b0, r_s};
        end else if (i_cmd.sh_wr) begin
            w_we    = 1'b1;
            w_waddr = r_j[IDX_W-1:0];
            w_wdata = w_rdata;
        end
    end

    wfba_ram #(
        .WIDTH (SEG_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= '0;
            r_header     <= 7'd24;
            r_heap_limit <= '1;
            r_count      <= '0;
            r_top        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HEAP_BASE:    r_heap_base  <= i_cfg_data;
                    CFG_HEADER_BYTES: r_header     <= i_cfg_data[6:0];
                    CFG_HEAP_LIMIT:   r_heap_limit <= i_cfg_data;
                    default:          ;
                endcase
            end
            if (i_cmd.alloc_fin && !r_found && !w_no_room) begin
                r_count <= r_count + CNT_W'(1);
                r_top   <= w_app_sum[31:0];
            end
            if (i_cmd.free_mg) begin
                if (w_merge_last) begin
                    r_top   <= r_top - r_s;
                    r_count <= r_cntp - CNT_W'(1);
                end else begin
                    r_count <= r_cntp;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op_free    <= (i_op == OP_FREE);
            r_need       <= {1'b0, i_request_size} + {{(NEED_W-7){1'b0}}, r_header};
            r_best       <= {{(SIZE_W-NEED_W){1'b0}},
                             ({1'b0, i_request_size} + {{(NEED_W-7){1'b0}}, r_header})};
            r_baddr      <= i_block_address;
            r_basehdr    <= r_heap_base + {25'd0, r_header};
            r_idx        <= '0;
            r_off        <= '0;
            r_found      <= 1'b0;
            r_prev_used  <= 1'b1;
            r_res_addr   <= '0;
            r_res_status <= ST_UNKNOWN;
        end
        if (i_cmd.scan) begin
            if (w_match) begin
                r_i <= r_idx;
                r_s <= rd_size;
            end else begin
                if (!r_op_free && !rd_used && (rd_size >= r_best)) begin
                    r_best     <= rd_size;
                    r_pick     <= r_idx;
                    r_pick_off <= r_off;
                    r_found    <= 1'b1;
                end
                r_prev_size <= rd_size;
                r_prev_used <= rd_used;
                r_off       <= r_off + rd_size;
                r_idx       <= r_idx + IDX_W'(1);
            end
        end
        if (i_cmd.alloc_fin) begin
            if (r_found) begin
                r_res_addr   <= r_basehdr + r_pick_off;
                r_res_status <= ST_REUSED;
            end else if (w_no_room) begin
                r_res_addr   <= '0;
                r_res_status <= ST_NO_ROOM;
            end else begin
                r_res_addr   <= r_basehdr + r_top;
                r_res_status <= ST_APPENDED;
            end
        end
        if (i_cmd.free_nx) begin
            // rdata holds entry i+1 here (read issued on the matching scan beat)
            r_s    <= r_s + (w_next_free ? rd_size : 32'd0);
            r_m    <= r_i - IDX_W'(w_prev_free);
            r_k    <= w_k;
            r_cntp <= r_count - CNT_W'(w_k);
            r_pf   <= w_prev_free;
        end
        if (i_cmd.free_sum) begin
            r_s <= r_s + (r_pf ? r_prev_size : 32'd0);
        end
        if (i_cmd.free_mg) begin
            r_j          <= {1'b0, r_m} + CNT_W'(1);
            r_res_addr   <= '0;
            r_res_status <= ST_FREED;
        end
        if (i_cmd.sh_wr) begin
            r_j <= r_j + CNT_W'(1);
        end
        if (i_cmd.load_out) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
            r_out_used   <= r_top;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_address = r_out_addr;
    assign o_status         = r_out_status;
    assign o_heap_used      = r_out_used;

endmodule

`default_nettype wire

FILE: sv/worst_fit_block_allocator.sv
//------------------------------------------------------------------------------
// worst_fit_block_allocator
// Worst-fit heap allocator over an address-ordered segment table with
// neighbor coalescing on free.
//------------------------------------------------------------------------------
// One item in flight; the next is taken in the cycle after the result is
// loaded. A free moves later table entries down after a merge. The scan
// through the single-read table RAM sets the rate. Synchronous active-low
// reset: empty table, heap top 0, config at defaults; table RAM itself is
// not cleared.
//------------------------------------------------------------------------------
`default_nettype none

module worst_fit_block_allocator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    wfba_in_if.sink                            i_in,
    wfba_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [wfba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);
    import wfba_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer: idle -> scan table (skipped when empty) -> finish (alloc) or
    // merge/compact (free) -> wait for the result register.
    wfba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Table RAM, heap state, config registers and result beat register.
    wfba_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_op             (i_in.op),
        .i_request_size   (i_in.request_size),
        .i_block_address  (i_in.block_address),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_result_address (o_out.result_address),
        .o_status         (o_out.status),
        .o_heap_used      (o_out.heap_used)
    );

`ifndef SYNTHESIS
    // one item at a time: an accepted beat closes the input until done
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while an item is in flight");

    // a result beat only appears after the sequencer loads it
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_cmd.load_out))
        else $error("result valid without a load");

    // no table write (allocate finish, merge or shift) coincides with a scan beat
    a_no_scan_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan |-> !(w_cmd.free_mg || w_cmd.sh_wr || w_cmd.alloc_fin))
        else $error("table write during scan");
`endif

endmodule

`default_nettype wire
